@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each check is clocked on clk and
// switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define CCE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication: whenever ante holds, cons holds in the cycle after.
`define CCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hw/rtl/cce_pkg.sv @@
package cce_pkg;

    // Largest generator degree supported by default.
    localparam int MAX_DEGREE_DEF = 32;

    // Entries in the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Fixed register and field widths.
    localparam int GEN_W  = 33;
    localparam int DEG_W  = 6;
    localparam int CFG_IW = 2;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] CFG_GENERATOR = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_DEGREE    = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_CHECK     = 2'd2;

    // Kind of an output beat.
    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_TAIL    = 2'd1,
        KIND_VERDICT = 2'd2
    } cce_kind_t;

    // Verdict status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ERROR    = 2'd1,
        ST_IMPROPER = 2'd2,
        ST_SHORT    = 2'd3
    } cce_status_t;

    // What follows the data beat of an item.
    typedef enum logic [1:0] {
        END_NONE    = 2'd0,
        END_VERDICT = 2'd1,
        END_TAIL    = 2'd2
    } cce_end_t;

    // Live configuration registers.
    typedef struct packed {
        logic [GEN_W-1:0] generator_bits;
        logic [DEG_W-1:0] generator_degree;
        logic             check_mode;
    } cce_cfg_t;

    // Classified item handed from front to back.
    typedef struct packed {
        logic             data_bit;
        logic             quotient_bit;
        cce_end_t         end_kind;
        cce_status_t      status;
        logic [DEG_W-1:0] degree;
    } cce_cmd_t;

endpackage

@@ hw/rtl/programmable_crc_encode_check_unit.sv @@
// Data beats reach the outputs through the queue and the output beat register.
// Throughput: one bit per cycle while the queue is not full; the output sequencer
// adds one tail beat per remainder bit to an encoded frame, or else a verdict beat.
// The four-entry queue absorbs input bits while the tail bits drain.
// Reset (rst_n low, asynchronous) clears remainder, bit count, queue and
// output valid, and sets generator 0, degree 1, encode mode.
`include "assert_macros.svh"

module programmable_crc_encode_check_unit #(
    parameter int MAX_DEGREE = cce_pkg::MAX_DEGREE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [cce_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [cce_pkg::GEN_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         data_bit,
    input  logic                         frame_last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   result_kind,
    output logic                         frame_bit,
    output logic                         quotient_bit,
    output logic [1:0]                   status,
    output logic                         run_last
);

    cce_pkg::cce_cfg_t     cfg_reg;
    cce_pkg::cce_cfg_t     cfg_next;
    logic                  q_full;
    logic                  q_empty;
    logic                  push;
    logic                  pop;
    cce_pkg::cce_cmd_t     push_cmd;
    cce_pkg::cce_cmd_t     head_cmd;
    logic [MAX_DEGREE-1:0] push_rem;
    logic [MAX_DEGREE-1:0] head_rem;
    logic                  tail_beat;
    logic                  verdict_beat;

    // Configuration register writes; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                cce_pkg::CFG_GENERATOR: cfg_next.generator_bits   = cfg_data;
                cce_pkg::CFG_DEGREE:    cfg_next.generator_degree = cfg_data[5:0];
                cce_pkg::CFG_CHECK:     cfg_next.check_mode       = cfg_data[0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.generator_bits   <= '0;
            cfg_reg.generator_degree <= 6'd1;
            cfg_reg.check_mode       <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: division step and frame classification.
    cce_front #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_bit   (data_bit),
        .frame_last (frame_last),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_rem   (push_rem)
    );

    // Queue between front and back.
    cce_queue #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .push_rem (push_rem),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_cmd (head_cmd),
        .head_rem (head_rem)
    );

    // Back: expands each entry into its output beats.
    cce_back #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .head_cmd     (head_cmd),
        .head_rem     (head_rem),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .frame_bit    (frame_bit),
        .quotient_bit (quotient_bit),
        .status       (status),
        .run_last     (run_last)
    );

    // Kind of the beat currently offered.
    assign tail_beat    = out_valid && (result_kind == cce_pkg::KIND_TAIL);
    assign verdict_beat = out_valid && (result_kind == cce_pkg::KIND_VERDICT);

    // A taken beat that is not the last of its item is followed at once by another.
    `CCE_ASSERT_NEXT(a_run_continues, out_valid && !out_stall && !run_last, out_valid)

    // Tail beats carry no quotient bit and no status.
    `CCE_ASSERT_IMPL(a_tail_clean, tail_beat, !quotient_bit && status == cce_pkg::ST_OK)

    // A verdict always closes its item.
    `CCE_ASSERT_IMPL(a_verdict_last, verdict_beat, run_last && !frame_bit)

endmodule

@@ hw/rtl/cce_front.sv @@
module cce_front #(
    parameter int MAX_DEGREE = cce_pkg::MAX_DEGREE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cce_pkg::cce_cfg_t     cfg,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  data_bit,
    input  logic                  frame_last,
    input  logic                  q_full,
    output logic                  push,
    output cce_pkg::cce_cmd_t     push_cmd,
    output logic [MAX_DEGREE-1:0] push_rem
);

    localparam int RemW = MAX_DEGREE;
    localparam int IdxW = (RemW > 1) ? $clog2(RemW) : 1;
    localparam logic [cce_pkg::DEG_W:0] MaxDeg = (cce_pkg::DEG_W + 1)'(MAX_DEGREE);
    localparam logic [cce_pkg::DEG_W-1:0] SeenMax = '1;

    logic [RemW-1:0]           rem_reg;
    logic [RemW-1:0]           rem_next;
    logic [cce_pkg::DEG_W-1:0] seen_reg;
    logic [cce_pkg::DEG_W-1:0] seen_next;

    logic                      accept;
    logic                      deg_ok;
    logic                      msb;
    logic                      qbit;
    logic                      gen_lead;
    logic                      proper;
    logic                      too_short;
    logic [RemW-1:0]           mask;
    logic [RemW-1:0]           gen_ext;
    logic [RemW-1:0]           shifted;
    logic [RemW-1:0]           rem_upd;
    logic [cce_pkg::DEG_W-1:0] seen_inc;
    logic [IdxW-1:0]           msb_idx;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Remainder mask of the current degree.
    always_comb
    begin
        for (int i = 0; i < RemW; i++)
        begin
            mask[i] = (i < int'(cfg.generator_degree));
        end
    end

    // One division step: shift, feed back the quotient bit through the generator.
    always_comb
    begin
        deg_ok  = (cfg.generator_degree != '0) &&
                  ({1'b0, cfg.generator_degree} <= MaxDeg);
        msb_idx = IdxW'(cfg.generator_degree - 6'd1);
        msb     = deg_ok ? rem_reg[msb_idx] : 1'b0;
        qbit    = deg_ok ? (msb ^ data_bit) : 1'b0;
        gen_ext = RemW'(cfg.generator_bits);
        shifted = (rem_reg << 1) & mask;
        if (!deg_ok)
        begin
            rem_upd = rem_reg;
        end
        else if (qbit)
        begin
            rem_upd = shifted ^ (gen_ext & mask);
        end
        else
        begin
            rem_upd = shifted;
        end
    end

    // Frame length count and generator sanity.
    always_comb
    begin
        seen_inc  = (seen_reg == SeenMax) ? seen_reg : seen_reg + 6'd1;
        gen_lead  = (cfg.generator_degree <= 6'd32) &&
                    cfg.generator_bits[cfg.generator_degree];
        proper    = deg_ok && gen_lead && cfg.generator_bits[0];
        too_short = (seen_inc <= cfg.generator_degree);
    end

    // Classify the item for the back end.
    always_comb
    begin
        push_cmd.data_bit     = data_bit;
        push_cmd.quotient_bit = qbit;
        push_cmd.degree       = cfg.generator_degree;
        push_cmd.end_kind     = cce_pkg::END_NONE;
        push_cmd.status       = cce_pkg::ST_OK;
        if (frame_last)
        begin
            priority if (!proper)
            begin
                push_cmd.end_kind = cce_pkg::END_VERDICT;
                push_cmd.status   = cce_pkg::ST_IMPROPER;
            end
            else if (too_short)
            begin
                push_cmd.end_kind = cce_pkg::END_VERDICT;
                push_cmd.status   = cce_pkg::ST_SHORT;
            end
            else if (cfg.check_mode)
            begin
                push_cmd.end_kind = cce_pkg::END_VERDICT;
                push_cmd.status   = (rem_upd != '0) ? cce_pkg::ST_ERROR : cce_pkg::ST_OK;
            end
            else
            begin
                push_cmd.end_kind = cce_pkg::END_TAIL;
            end
        end
        push     = accept;
        push_rem = rem_upd;
    end

    // State update; the end of a frame clears the remainder and the bit count.
    always_comb
    begin
        rem_next  = rem_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            if (frame_last)
            begin
                rem_next  = '0;
                seen_next = '0;
            end
            else
            begin
                rem_next  = rem_upd;
                seen_next = seen_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            seen_reg <= '0;
        end
        else
        begin
            rem_reg  <= rem_next;
            seen_reg <= seen_next;
        end
    end

endmodule

@@ hw/rtl/cce_queue.sv @@
module cce_queue #(
    parameter int MAX_DEGREE = cce_pkg::MAX_DEGREE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cce_pkg::cce_cmd_t     push_cmd,
    input  logic [MAX_DEGREE-1:0] push_rem,
    input  logic                  pop,
    output logic                  full,
    output logic                  empty,
    output cce_pkg::cce_cmd_t     head_cmd,
    output logic [MAX_DEGREE-1:0] head_rem
);

    localparam int Depth = cce_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    cce_pkg::cce_cmd_t     cmd_mem [Depth];
    logic [MAX_DEGREE-1:0] rem_mem [Depth];

    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == CntW'(Depth));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = cmd_mem[rd_ptr_reg];
    assign head_rem = rem_mem[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cmd_mem[wr_ptr_reg] <= push_cmd;
            rem_mem[wr_ptr_reg] <= push_rem;
        end
    end

endmodule

@@ hw/rtl/cce_back.sv @@
module cce_back #(
    parameter int MAX_DEGREE = cce_pkg::MAX_DEGREE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  cce_pkg::cce_cmd_t     head_cmd,
    input  logic [MAX_DEGREE-1:0] head_rem,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            result_kind,
    output logic                  frame_bit,
    output logic                  quotient_bit,
    output logic [1:0]            status,
    output logic                  run_last
);

    localparam int RemW = MAX_DEGREE;
    localparam int IdxW = (RemW > 1) ? $clog2(RemW) : 1;

    logic [cce_pkg::DEG_W-1:0] phase_reg;
    logic [cce_pkg::DEG_W-1:0] phase_next;
    logic                      valid_reg;
    logic                      valid_next;
    cce_pkg::cce_kind_t        kind_reg;
    cce_pkg::cce_kind_t        kind_next;
    logic                      fbit_reg;
    logic                      fbit_next;
    logic                      qbit_reg;
    logic                      qbit_next;
    cce_pkg::cce_status_t      status_reg;
    cce_pkg::cce_status_t      status_next;
    logic                      last_reg;
    logic                      last_next;

    logic                      load_en;
    logic                      fire;
    logic [IdxW-1:0]           tail_idx;

    assign load_en  = !valid_reg || !out_stall;
    assign fire     = load_en && !q_empty;
    assign tail_idx = IdxW'(head_cmd.degree - phase_reg);

    // Beat sequencer: data beat, then at frame end a verdict or remainder bits.
    always_comb
    begin
        phase_next  = phase_reg;
        valid_next  = valid_reg;
        kind_next   = kind_reg;
        fbit_next   = fbit_reg;
        qbit_next   = qbit_reg;
        status_next = status_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        if (load_en)
        begin
            valid_next = !q_empty;
        end
        if (fire)
        begin
            if (phase_reg == '0)
            begin
                kind_next   = cce_pkg::KIND_DATA;
                fbit_next   = head_cmd.data_bit;
                qbit_next   = head_cmd.quotient_bit;
                status_next = cce_pkg::ST_OK;
                last_next   = (head_cmd.end_kind == cce_pkg::END_NONE);
                if (head_cmd.end_kind == cce_pkg::END_NONE)
                begin
                    pop = 1'b1;
                end
                else
                begin
                    phase_next = 6'd1;
                end
            end
            else if (head_cmd.end_kind == cce_pkg::END_VERDICT)
            begin
                kind_next   = cce_pkg::KIND_VERDICT;
                fbit_next   = 1'b0;
                qbit_next   = 1'b0;
                status_next = head_cmd.status;
                last_next   = 1'b1;
                pop         = 1'b1;
                phase_next  = '0;
            end
            else
            begin
                kind_next   = cce_pkg::KIND_TAIL;
                fbit_next   = head_rem[tail_idx];
                qbit_next   = 1'b0;
                status_next = cce_pkg::ST_OK;
                last_next   = (phase_reg == head_cmd.degree);
                if (phase_reg == head_cmd.degree)
                begin
                    pop        = 1'b1;
                    phase_next = '0;
                end
                else
                begin
                    phase_next = phase_reg + 6'd1;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    // Output beat register.
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        fbit_reg   <= fbit_next;
        qbit_reg   <= qbit_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign out_valid    = valid_reg;
    assign result_kind  = kind_reg;
    assign frame_bit    = fbit_reg;
    assign quotient_bit = qbit_reg;
    assign status       = status_reg;
    assign run_last     = last_reg;

endmodule

@@ verif/crc_result_checker.sv @@
module crc_result_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cce_pkg::CFG_IW-1:0] cfg_index,
    input  logic [cce_pkg::GEN_W-1:0]  cfg_data,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       data_bit,
    input  logic                       frame_last,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [1:0]                 result_kind,
    input  logic                       frame_bit,
    input  logic                       quotient_bit,
    input  logic [1:0]                 status,
    input  logic                       run_last,
    output int unsigned                beats_outstanding,
    output int unsigned                mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // One predicted output beat.
    typedef struct packed {
        cce_pkg::cce_kind_t   kind;
        logic                 fbit;
        logic                 qbit;
        cce_pkg::cce_status_t st;
        logic                 last;
    } crc_beat_t;

    // Shadow of the configuration registers and of the division state.
    logic [cce_pkg::GEN_W-1:0] gen_coeffs;
    logic [cce_pkg::DEG_W-1:0] gen_degree;
    logic                      verify_mode;
    logic [31:0]               running_rem;
    logic [5:0]                frame_bits;

    crc_beat_t   expected_beats[$];
    int unsigned fails;

    function automatic crc_beat_t make_beat(cce_pkg::cce_kind_t k, logic f, logic q,
                                            cce_pkg::cce_status_t s, logic l);
        crc_beat_t b;
        b.kind = k;
        b.fbit = f;
        b.qbit = q;
        b.st   = s;
        b.last = l;
        return b;
    endfunction

    // Divide by one more bit and queue every beat that this bit causes.
    task automatic divide_bit(input logic din, input logic fin);
        logic [63:0] mask;
        logic [63:0] next_rem;
        logic        q;
        logic        deg_ok;
        logic        proper;
        int unsigned d;
        d      = gen_degree;
        q      = 1'b0;
        deg_ok = (d >= 1) && (d <= cce_pkg::MAX_DEGREE_DEF);
        proper = 1'b0;
        if (deg_ok)
        begin
            mask     = (64'd1 << d) - 64'd1;
            q        = running_rem[d-1] ^ din;
            next_rem = ({32'd0, running_rem} << 1) & mask;
            if (q)
            begin
                next_rem = next_rem ^ ({31'd0, gen_coeffs} & mask);
            end
            running_rem = next_rem[31:0];
            proper      = gen_coeffs[d] && gen_coeffs[0];
        end
        if (frame_bits != 6'd63)
        begin
            frame_bits = frame_bits + 6'd1;
        end
        expected_beats.push_back(make_beat(cce_pkg::KIND_DATA, din, q, cce_pkg::ST_OK, !fin));

        // At the end of a frame: a verdict, or the remainder as the frame tail.
        if (fin)
        begin
            if (!proper)
            begin
                expected_beats.push_back(make_beat(cce_pkg::KIND_VERDICT, 1'b0, 1'b0,
                                                   cce_pkg::ST_IMPROPER, 1'b1));
            end
            else if (frame_bits <= d)
            begin
                expected_beats.push_back(make_beat(cce_pkg::KIND_VERDICT, 1'b0, 1'b0,
                                                   cce_pkg::ST_SHORT, 1'b1));
            end
            else if (verify_mode)
            begin
                expected_beats.push_back(make_beat(cce_pkg::KIND_VERDICT, 1'b0, 1'b0,
                    (running_rem != 32'd0) ? cce_pkg::ST_ERROR : cce_pkg::ST_OK, 1'b1));
            end
            else
            begin
                for (int i = d; i > 0; i--)
                begin
                    expected_beats.push_back(make_beat(cce_pkg::KIND_TAIL,
                                                       running_rem[i-1], 1'b0,
                                                       cce_pkg::ST_OK, i == 1));
                end
            end
            running_rem = 32'd0;
            frame_bits  = 6'd0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        crc_beat_t want;
        if (!rst_n)
        begin
            gen_coeffs   = '0;
            gen_degree   = 6'd1;
            verify_mode  = 1'b0;
            running_rem  = 32'd0;
            frame_bits   = 6'd0;
            fails        = 0;
            expected_beats.delete();
            beats_outstanding <= 0;
            mismatch_count    <= 0;
        end
        else
        begin
            // Compare an accepted output beat with the oldest prediction.
            if (out_valid && !out_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                    begin
                        $display("unexpected beat: kind %0d frame %0b quot %0b st %0d last %0b",
                                 result_kind, frame_bit, quotient_bit, status, run_last);
                    end
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (want.kind != result_kind || want.fbit != frame_bit ||
                        want.qbit != quotient_bit || want.st != status ||
                        want.last != run_last)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display("mismatch at %0t: exp kind %0d fr %0b qu %0b st %0d ls %0b",
                                     $realtime, want.kind, want.fbit, want.qbit, want.st,
                                     want.last);
                            $display("  got kind %0d fr %0b qu %0b st %0d ls %0b",
                                     result_kind, frame_bit, quotient_bit, status, run_last);
                        end
                    end
                end
            end

            // A bit accepted at this edge still sees the old register values.
            if (in_valid && !in_stall)
            begin
                divide_bit(data_bit, frame_last);
            end

            // Track register writes; an unused index changes nothing.
            if (cfg_we)
            begin
                case (cfg_index)
                    cce_pkg::CFG_GENERATOR: gen_coeffs  = cfg_data;
                    cce_pkg::CFG_DEGREE:    gen_degree  = cfg_data[cce_pkg::DEG_W-1:0];
                    cce_pkg::CFG_CHECK:     verify_mode = cfg_data[0];
                    default:                ;
                endcase
            end

            beats_outstanding <= expected_beats.size();
            mismatch_count    <= fails;
        end
    end

endmodule

@@ verif/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [cce_pkg::CFG_IW-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 130;
    localparam int unsigned HOLD_CYCLES  = 400;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       cfg_we      = 1'b0;
    logic [cce_pkg::CFG_IW-1:0] cfg_index   = '0;
    logic [cce_pkg::GEN_W-1:0]  cfg_data    = '0;
    logic                       in_valid    = 1'b0;
    logic                       data_bit    = 1'b0;
    logic                       frame_last  = 1'b0;
    logic                       out_stall   = 1'b0;
    logic                       in_stall;
    logic                       out_valid;
    logic [1:0]                 result_kind;
    logic                       frame_bit;
    logic                       quotient_bit;
    logic [1:0]                 status;
    logic                       run_last;

    int unsigned beats_outstanding;
    int unsigned mismatch_count;
    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;

    // Tail of the run without idling, and the one long receiver hold-off.
    logic calm          = 1'b0;
    logic long_hold_req = 1'b0;

    // Current register values, used to build valid codewords.
    logic [cce_pkg::GEN_W-1:0] shadow_gen = '0;
    logic [cce_pkg::DEG_W-1:0] shadow_deg = 6'd1;
    logic                      shadow_chk = 1'b0;

    logic        frame_buf [0:127];
    int unsigned frame_len;

    programmable_crc_encode_check_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_bit     (data_bit),
        .frame_last   (frame_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .frame_bit    (frame_bit),
        .quotient_bit (quotient_bit),
        .status       (status),
        .run_last     (run_last)
    );

    crc_result_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .data_bit          (data_bit),
        .frame_last        (frame_last),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .result_kind       (result_kind),
        .frame_bit         (frame_bit),
        .quotient_bit      (quotient_bit),
        .status            (status),
        .run_last          (run_last),
        .beats_outstanding (beats_outstanding),
        .mismatch_count    (mismatch_count)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Receiver: random stall bursts, quiet stretches and one long hold-off.
    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                repeat ($urandom_range(0, 20)) @(posedge clk);
            end
        end
    end

    function automatic logic [cce_pkg::GEN_W-1:0] rand33();
        logic [cce_pkg::GEN_W-1:0] v;
        v[31:0] = $urandom();
        v[32]   = 1'($urandom_range(0, 1));
        return v;
    endfunction

    // Offer one bit, with an occasional idle burst before it.
    task automatic send_beat(input logic b, input logic l);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_bit   <= b;
        frame_last <= l;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_len; i++)
        begin
            send_beat(frame_buf[i], i == frame_len - 1);
        end
    endtask

    // Stop offering and wait until every predicted beat has come out.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (beats_outstanding != 0);
    endtask

    // Write all registers plus the unused index; random bits above the narrow fields.
    task automatic program_regs(input logic [cce_pkg::GEN_W-1:0] gen,
                                input logic [cce_pkg::DEG_W-1:0] deg, input logic chk);
        logic [cce_pkg::GEN_W-1:0] v;
        cfg_we    <= 1'b1;
        cfg_index <= cce_pkg::CFG_GENERATOR;
        cfg_data  <= gen;
        @(posedge clk);
        v         = rand33();
        v[5:0]    = deg;
        cfg_index <= cce_pkg::CFG_DEGREE;
        cfg_data  <= v;
        @(posedge clk);
        v         = rand33();
        v[0]      = chk;
        cfg_index <= cce_pkg::CFG_CHECK;
        cfg_data  <= v;
        @(posedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= rand33();
        @(posedge clk);
        cfg_we     <= 1'b0;
        shadow_gen = gen;
        shadow_deg = deg;
        shadow_chk = chk;
    endtask

    // Remainder of the first n buffered bits times x^d under the current generator.
    function automatic logic [31:0] residue(input int unsigned n);
        logic [63:0] rem;
        logic [63:0] mask;
        logic        fb;
        mask = (64'd1 << shadow_deg) - 64'd1;
        rem  = '0;
        for (int i = 0; i < n; i++)
        begin
            fb  = rem[shadow_deg-1] ^ frame_buf[i];
            rem = (rem << 1) & mask;
            if (fb)
            begin
                rem = rem ^ ({31'd0, shadow_gen} & mask);
            end
        end
        return rem[31:0];
    endfunction

    // Fill the frame buffer: random bits, or a message with its remainder appended.
    task automatic build_frame(input int unsigned len, input logic codeword);
        logic [31:0] rem;
        int unsigned pos;
        for (int i = 0; i < len; i++)
        begin
            frame_buf[i] = 1'($urandom_range(0, 1));
        end
        frame_len = len;
        if (codeword)
        begin
            rem = residue(len);
            for (int i = shadow_deg; i > 0; i--)
            begin
                frame_buf[frame_len] = rem[i-1];
                frame_len++;
            end
            // Corrupt a single bit about half the time.
            if ($urandom_range(0, 1) == 1)
            begin
                pos            = $urandom_range(0, frame_len - 1);
                frame_buf[pos] = !frame_buf[pos];
            end
        end
    endtask

    // Pick a new register setting, weighted toward small proper generators.
    task automatic random_setting();
        logic [cce_pkg::GEN_W-1:0] g;
        logic [cce_pkg::DEG_W-1:0] d;
        int unsigned               pick;
        pick = $urandom_range(0, 19);
        g    = rand33();
        if (pick == 0)
        begin
            d = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
        end
        else if (pick == 1)
        begin
            d = 6'($urandom_range(1, 12));
            if ($urandom_range(0, 1) == 0)
            begin
                g[d] = 1'b0;
            end
            else
            begin
                g[0] = 1'b0;
            end
        end
        else
        begin
            if (pick == 2)
            begin
                d = 6'd32;
            end
            else if (pick == 3)
            begin
                d = 6'd31;
            end
            else
            begin
                d = 6'($urandom_range(1, 12));
            end
            g[d] = 1'b1;
            g[0] = 1'b1;
        end
        drain();
        program_regs(g, d, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned deg_now;
        logic        deg_ok;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: zero generator is improper.
        send_beat(1'b1, 1'b1);

        // Degree zero: remainder frozen, improper verdict.
        drain();
        program_regs({cce_pkg::GEN_W{1'b1}}, 6'd0, 1'b0);
        send_beat(1'b1, 1'b0);
        send_beat(1'b1, 1'b1);

        // Largest degree code, check mode.
        drain();
        program_regs({cce_pkg::GEN_W{1'b1}}, 6'd63, 1'b1);
        send_beat(1'b0, 1'b1);

        // Constant term missing.
        drain();
        program_regs(33'h2, 6'd1, 1'b0);
        send_beat(1'b1, 1'b1);

        // Parity generator: a one-bit frame is too short, then a tail bit.
        drain();
        program_regs(33'h3, 6'd1, 1'b0);
        send_beat(1'b1, 1'b1);
        send_beat(1'b1, 1'b0);
        send_beat(1'b0, 1'b0);
        send_beat(1'b1, 1'b1);

        // Parity check: one clean frame, one with an error.
        drain();
        program_regs(33'h3, 6'd1, 1'b1);
        send_beat(1'b1, 1'b0);
        send_beat(1'b1, 1'b0);
        send_beat(1'b0, 1'b1);
        send_beat(1'b1, 1'b0);
        send_beat(1'b1, 1'b0);
        send_beat(1'b1, 1'b1);

        // Full 32-bit generator: a short frame.
        drain();
        program_regs(33'h1_04C1_1DB7, 6'd32, 1'b0);
        send_beat(1'b1, 1'b1);

        // Long receiver hold-off while a long encoded frame keeps arriving.
        drain();
        program_regs(33'h13, 6'd4, 1'b0);
        long_hold_req <= 1'b1;
        build_frame(40, 1'b0);
        send_frame();

        // Random frames under changing settings.
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent + 30 >= RANDOM_ITEMS)
            begin
                calm <= 1'b1;
            end
            if ($urandom_range(0, 1) == 0)
            begin
                random_setting();
            end
            deg_now = shadow_deg;
            deg_ok  = deg_now >= 1 && deg_now <= cce_pkg::MAX_DEGREE_DEF &&
                      shadow_gen[deg_now] && shadow_gen[0];
            pick    = $urandom_range(0, 9);
            if (!deg_ok)
            begin
                build_frame($urandom_range(1, 10), 1'b0);
            end
            else if (pick == 0)
            begin
                build_frame($urandom_range(1, deg_now), 1'b0);
            end
            else if (pick == 1 && deg_now <= 8)
            begin
                build_frame($urandom_range(60, 70), 1'b0);
            end
            else if (shadow_chk && pick >= 4)
            begin
                build_frame($urandom_range(1, 6), 1'b1);
            end
            else
            begin
                build_frame(deg_now + $urandom_range(1, 6), 1'b0);
            end
            send_frame();
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && beats_outstanding == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/cce_pkg.sv
hw/rtl/cce_front.sv
hw/rtl/cce_queue.sv
hw/rtl/cce_back.sv
hw/rtl/programmable_crc_encode_check_unit.sv
verif/crc_result_checker.sv
verif/testbench.sv
